[hdl/mqtf_pkg.sv]
// ----------------------------------------------------------------------------
// mqtf_pkg
// Shared types and constants for the multi-queue ticket FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mqtf_pkg;

  localparam int QUEUE_COUNT    = 4;
  localparam int QUEUE_CAPACITY = 8;
  localparam int PAYLOAD_BITS   = 16;

  localparam int SlotTotal = QUEUE_COUNT * QUEUE_CAPACITY;
  localparam int QueueIdxW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PtrW      = $clog2(QUEUE_CAPACITY);
  localparam int CountW    = $clog2(QUEUE_CAPACITY + 1);
  localparam int SlotW     = (SlotTotal > 1) ? $clog2(SlotTotal) : 1;
  localparam int TicketW   = 32;
  localparam int ActionW   = 1;
  localparam int QueueSelW = 2;
  localparam int PayloadW  = PAYLOAD_BITS;

  typedef enum logic [ActionW-1:0] {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    CMD_FAIL,
    CMD_ENQ,
    CMD_DEQ
  } cmd_kind_e;

  // Classified request passed from front to back
  typedef struct packed {
    cmd_kind_e            kind;
    logic [SlotW-1:0]     slot;
    logic [TicketW-1:0]   ticket;
    logic [PayloadW-1:0]  payload;
  } cmd_t;

  // One slot of the shared store
  typedef struct packed {
    logic [TicketW-1:0]   ticket;
    logic [PayloadW-1:0]  payload;
  } slot_t;

  // Handshake between a producer and the command queue
  typedef struct packed {
    logic push;
    logic full;
  } push_ctl_t;

endpackage

`default_nettype wire

[hdl/multi_queue_ticket_fifo_top.sv]
// ----------------------------------------------------------------------------
// multi_queue_ticket_fifo_top
// Several circular FIFOs in one shared slot store with a global ticket
// counter; each request gives one result.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Fields
// request   in         in_valid_i / in_stall_o  action_i, queue_index_i,
//                                               payload_handle_i
// result    out        out_valid_o / out_stall_i success_o, ticket_number_o,
//                                               payload_out_o
//
// One request per cycle sustained while in_stall_o is low; a request is
// first written into the request queue, then popped into the back's
// result register, which drives out_valid_o.
// Reset clears pointers, counts and sets the ticket counter to one; the
// slot store is not cleared, so no clearing pass is run.
// A two-entry request queue parts front and back; in_stall_o rises only
// when it is full because the result side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_queue_ticket_fifo_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [0:0]  action_i,
  input  wire logic [1:0]  queue_index_i,
  input  wire logic [15:0] payload_handle_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             success_o,
  output logic [31:0]      ticket_number_o,
  output logic [15:0]      payload_out_o
);
  import mqtf_pkg::*;

  push_ctl_t ctl;
  cmd_t      front_cmd;
  cmd_t      back_cmd;
  logic      fifo_full;
  logic      fifo_valid;
  logic      fifo_pop;

  // Classify requests
  mqtf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .queue_index_i    (queue_index_i),
    .payload_handle_i (payload_handle_i),
    .ctl_o            (ctl),
    .queue_full_i     (fifo_full),
    .cmd_o            (front_cmd)
  );

  // Buffer classified requests
  mqtf_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (fifo_pop),
    .cmd_o   (back_cmd)
  );

  // Execute on the slot store
  mqtf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (fifo_valid),
    .cmd_pop_o       (fifo_pop),
    .cmd_i           (back_cmd),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .success_o       (success_o),
    .ticket_number_o (ticket_number_o),
    .payload_out_o   (payload_out_o)
  );

endmodule

`default_nettype wire

[hdl/mqtf_front.sv]
// ----------------------------------------------------------------------------
// mqtf_front
// Accepts requests, checks queue occupancy, assigns tickets and slot
// addresses, and updates the per-queue pointers, counts and ticket counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mqtf_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mqtf_pkg::ActionW-1:0]  action_i,
  input  wire logic [mqtf_pkg::QueueSelW-1:0] queue_index_i,
  input  wire logic [15:0]                   payload_handle_i,
  output mqtf_pkg::push_ctl_t                ctl_o,
  input  wire logic                          queue_full_i,
  output mqtf_pkg::cmd_t                     cmd_o
);
  import mqtf_pkg::*;

  logic [PtrW-1:0]    rd_ptr_q [QUEUE_COUNT];
  logic [PtrW-1:0]    rd_ptr_d [QUEUE_COUNT];
  logic [PtrW-1:0]    wr_ptr_q [QUEUE_COUNT];
  logic [PtrW-1:0]    wr_ptr_d [QUEUE_COUNT];
  logic [CountW-1:0]  fill_q   [QUEUE_COUNT];
  logic [CountW-1:0]  fill_d   [QUEUE_COUNT];
  logic [TicketW-1:0] ticket_q, ticket_d;

  logic                 accept;
  logic                 q_in_range;
  logic [QueueIdxW-1:0] qi;
  logic [PtrW-1:0]      ptr_sel;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_CAPACITY - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign accept     = in_valid_i && !queue_full_i;
  assign in_stall_o = queue_full_i;
  assign q_in_range = int'(queue_index_i) < QUEUE_COUNT;
  assign qi         = QueueIdxW'(queue_index_i);

  // Classify the request and compute the next queue state
  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    fill_d       = fill_q;
    ticket_d     = ticket_q;
    ptr_sel      = '0;
    cmd_o.kind    = CMD_FAIL;
    cmd_o.slot    = '0;
    cmd_o.ticket  = '0;
    cmd_o.payload = payload_handle_i[PayloadW-1:0];
    if (q_in_range) begin
      unique case (action_e'(action_i))
        ACT_ENQUEUE: begin
          if (fill_q[qi] < CountW'(QUEUE_CAPACITY)) begin
            ptr_sel      = wr_ptr_q[qi];
            cmd_o.kind   = CMD_ENQ;
            cmd_o.ticket = ticket_q;
            if (accept) begin
              wr_ptr_d[qi] = next_ptr(wr_ptr_q[qi]);
              fill_d[qi]   = fill_q[qi] + CountW'(1);
              ticket_d     = ticket_q + TicketW'(1);
            end
          end
        end
        ACT_DEQUEUE: begin
          if (fill_q[qi] != '0) begin
            ptr_sel    = rd_ptr_q[qi];
            cmd_o.kind = CMD_DEQ;
            if (accept) begin
              rd_ptr_d[qi] = next_ptr(rd_ptr_q[qi]);
              fill_d[qi]   = fill_q[qi] - CountW'(1);
            end
          end
        end
        default: ;
      endcase
    end
    cmd_o.slot = SlotW'(int'(qi) * QUEUE_CAPACITY + int'(ptr_sel));
  end

  assign ctl_o.push = accept;
  assign ctl_o.full = queue_full_i;

  // Hold queue state and the ticket counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        fill_q[i]   <= '0;
      end
      ticket_q <= TicketW'(1);
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      ticket_q <= ticket_d;
    end
  end

endmodule

`default_nettype wire

[hdl/mqtf_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// mqtf_cmd_fifo
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mqtf_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  mqtf_pkg::push_ctl_t  ctl_i,
  input  mqtf_pkg::cmd_t       cmd_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output mqtf_pkg::cmd_t       cmd_o
);
  import mqtf_pkg::*;

  localparam int Depth = 2;

  cmd_t       entry_q [Depth];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;

  assign full_o  = count_q == 2'(Depth);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_q];
  assign do_push = ctl_i.push && !ctl_i.full;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and count
  always_comb begin
    wr_d    = do_push ? ~wr_q : wr_q;
    rd_d    = do_pop ? ~rd_q : rd_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[hdl/mqtf_back.sv]
// ----------------------------------------------------------------------------
// mqtf_back
// Carries out classified requests on the shared slot store and holds the
// result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mqtf_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_pop_o,
  input  mqtf_pkg::cmd_t                     cmd_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               success_o,
  output logic [31:0]                        ticket_number_o,
  output logic [15:0]                        payload_out_o
);
  import mqtf_pkg::*;

  slot_t              slot_mem [SlotTotal];
  slot_t              rdata_q;
  cmd_kind_e          kind_q;
  logic [TicketW-1:0] ticket_q;
  logic               valid_q, valid_d;
  logic               pop;

  // Pop when the output register is free or being drained
  assign pop       = cmd_valid_i && (!valid_q || !out_stall_i);
  assign cmd_pop_o = pop;

  always_comb begin
    valid_d = valid_q;
    if (pop) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      kind_q  <= CMD_FAIL;
    end else begin
      valid_q <= valid_d;
      if (pop) begin
        kind_q <= cmd_i.kind;
      end
    end
  end

  // Write enqueued slots, read dequeued slots
  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.kind == CMD_ENQ) begin
      slot_mem[cmd_i.slot] <= '{ticket: cmd_i.ticket, payload: cmd_i.payload};
    end
    if (pop && cmd_i.kind == CMD_DEQ) begin
      rdata_q <= slot_mem[cmd_i.slot];
    end
    if (pop) begin
      ticket_q <= cmd_i.ticket;
    end
  end

  // Select result fields
  always_comb begin
    success_o       = 1'b0;
    ticket_number_o = '0;
    payload_out_o   = '0;
    unique case (kind_q)
      CMD_ENQ: begin
        success_o       = 1'b1;
        ticket_number_o = 32'(ticket_q);
      end
      CMD_DEQ: begin
        success_o       = 1'b1;
        ticket_number_o = 32'(rdata_q.ticket);
        payload_out_o   = 16'(rdata_q.payload);
      end
      default: ;
    endcase
  end

  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

[bench/multi_queue_ticket_fifo_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_ticket_fifo_top_tb
// Drives enqueue and dequeue requests into the multi-queue ticket FIFO with
// random gaps and result-side stalls. A scoreboard tracks every queue, its
// slots and the ticket counter. It checks each result field by field,
// oldest request first.
// ----------------------------------------------------------------------------

// Result of one request as the block should report it
typedef struct {
  logic                            ok;
  logic [mqtf_pkg::TicketW-1:0]    ticket;
  logic [mqtf_pkg::PayloadW-1:0]   payload;
} ticket_result_t;

// Tracks queue state and the results still owed by the block
class ticket_scoreboard;
  mqtf_pkg::slot_t                  slots [mqtf_pkg::SlotTotal];
  logic [mqtf_pkg::PtrW-1:0]        rd_ptr [mqtf_pkg::QUEUE_COUNT];
  logic [mqtf_pkg::PtrW-1:0]        wr_ptr [mqtf_pkg::QUEUE_COUNT];
  logic [mqtf_pkg::CountW-1:0]      fill [mqtf_pkg::QUEUE_COUNT];
  logic [mqtf_pkg::TicketW-1:0]     ticket_ctr;
  ticket_result_t                   owed_results [$];
  int                               errors;

  function new();
    for (int q = 0; q < mqtf_pkg::QUEUE_COUNT; q++) begin
      rd_ptr[q] = '0;
      wr_ptr[q] = '0;
      fill[q]   = '0;
    end
    ticket_ctr = 1;
    errors     = 0;
  endfunction

  function logic [mqtf_pkg::PtrW-1:0] bump(logic [mqtf_pkg::PtrW-1:0] p);
    return (p == mqtf_pkg::PtrW'(mqtf_pkg::QUEUE_CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function int depth(int q);
    return int'(fill[q]);
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  // Apply an accepted request and queue the result it must produce
  function void note_request(mqtf_pkg::action_e act, logic [1:0] q,
                             logic [mqtf_pkg::PayloadW-1:0] pay);
    ticket_result_t r;
    int             s;
    r.ok      = 1'b0;
    r.ticket  = '0;
    r.payload = '0;
    if (int'(q) < mqtf_pkg::QUEUE_COUNT) begin
      if (act == mqtf_pkg::ACT_ENQUEUE) begin
        if (fill[q] < mqtf_pkg::CountW'(mqtf_pkg::QUEUE_CAPACITY)) begin
          s = int'(q) * mqtf_pkg::QUEUE_CAPACITY + int'(wr_ptr[q]);
          slots[s].ticket  = ticket_ctr;
          slots[s].payload = pay;
          r.ok       = 1'b1;
          r.ticket   = ticket_ctr;
          ticket_ctr = ticket_ctr + 1'b1;
          wr_ptr[q]  = bump(wr_ptr[q]);
          fill[q]    = fill[q] + 1'b1;
        end
      end else begin
        if (fill[q] != '0) begin
          s = int'(q) * mqtf_pkg::QUEUE_CAPACITY + int'(rd_ptr[q]);
          r.ok      = 1'b1;
          r.ticket  = slots[s].ticket;
          r.payload = slots[s].payload;
          rd_ptr[q] = bump(rd_ptr[q]);
          fill[q]   = fill[q] - 1'b1;
        end
      end
    end
    owed_results.push_back(r);
  endfunction

  // Compare one accepted result against the oldest owed one
  function void check_result(logic ok, logic [mqtf_pkg::TicketW-1:0] ticket,
                             logic [mqtf_pkg::PayloadW-1:0] pay);
    ticket_result_t r;
    if (owed_results.size() == 0) begin
      $display("%0t: result with none pending: success %0d ticket %0d payload %0h",
               $time, ok, ticket, pay);
      errors++;
      return;
    end
    r = owed_results.pop_front();
    if (ok !== r.ok) begin
      $display("%0t: success mismatch: expected %0d actual %0d", $time, r.ok, ok);
      errors++;
    end
    if (ticket !== r.ticket) begin
      $display("%0t: ticket mismatch: expected %0d actual %0d", $time, r.ticket, ticket);
      errors++;
    end
    if (pay !== r.payload) begin
      $display("%0t: payload mismatch: expected %0h actual %0h", $time, r.payload, pay);
      errors++;
    end
  endfunction
endclass

module multi_queue_ticket_fifo_top_tb;
  import mqtf_pkg::*;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [0:0]  action_i = '0;
  logic [1:0]  queue_index_i = '0;
  logic [15:0] payload_handle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        success_o;
  logic [31:0] ticket_number_o;
  logic [15:0] payload_out_o;

  ticket_scoreboard sb;
  bit               hold_request = 1'b0;
  bit               run_done = 1'b0;

  multi_queue_ticket_fifo_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .queue_index_i,
    .payload_handle_i,
    .out_valid_o,
    .out_stall_i,
    .success_o,
    .ticket_number_o,
    .payload_out_o
  );

  // Run the clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #3ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap(bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(action_e act, logic [1:0] q, logic [15:0] pay);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    action_i         <= act;
    queue_index_i    <= q;
    payload_handle_i <= pay;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(act, q, pay);
  endtask

  // Drop valid for some cycles
  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Check every result taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(success_o, ticket_number_o, payload_out_o);
    end
  end

  // Stall the result side: free runs, short and long stalls, one long hold
  initial begin
    int free_len;
    int stall_len;
    @(posedge rst_ni);
    while (!run_done) begin
      if (hold_request) begin
        repeat (80) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        hold_request = 1'b0;
      end
      free_len  = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                            : $urandom_range(1, 6);
      stall_len = pick_gap(1'b0);
      repeat (free_len) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat (stall_len) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
    @(negedge clk_i);
    out_stall_i <= 1'b0;
  end

  // Main stimulus
  initial begin
    int          enq_pct;
    int          focus_q;
    bit          burst;
    action_e     act;
    logic [1:0]  q;
    int          waited;

    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty dequeue, payload extremes, fill one queue past full,
    // then drain it past empty
    send_request(ACT_DEQUEUE, 2'd0, 16'h1234);
    send_request(ACT_ENQUEUE, 2'd0, 16'h0000);
    send_request(ACT_ENQUEUE, 2'd3, 16'hFFFF);
    for (int i = 0; i < QUEUE_CAPACITY + 1; i++) begin
      send_request(ACT_ENQUEUE, 2'd1, (i % 2) ? 16'h5555 : 16'hAAAA ^ 16'(i));
    end
    send_request(ACT_DEQUEUE, 2'd0, 16'hFFFF);
    send_request(ACT_DEQUEUE, 2'd3, 16'h0000);
    for (int i = 0; i < QUEUE_CAPACITY + 1; i++) begin
      send_request(ACT_DEQUEUE, 2'd1, 16'(i));
      idle_sender(i % 3);
    end

    // Random: blocks with varying enqueue bias, queue focus and gap mode
    for (int blk = 0; blk < 12; blk++) begin
      case ($urandom_range(0, 3))
        0: enq_pct = 85;
        1: enq_pct = 15;
        2: enq_pct = 50;
        default: enq_pct = $urandom_range(0, 100);
      endcase
      focus_q = $urandom_range(0, QUEUE_COUNT - 1);
      burst   = ($urandom_range(0, 3) == 0);
      // Hold the result side off while requests keep coming
      if (blk == 2) begin
        hold_request = 1'b1;
        burst        = 1'b1;
        enq_pct      = 60;
      end
      for (int i = 0; i < 50; i++) begin
        act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
        q   = ($urandom_range(0, 1) == 0) ? 2'(focus_q)
                                          : 2'($urandom_range(0, QUEUE_COUNT - 1));
        send_request(act, q, 16'($urandom_range(0, 16'hFFFF)));
        idle_sender(pick_gap(burst));
      end
    end
    idle_sender(1);

    // Wait for outstanding results, then let the pipeline settle
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    run_done = 1'b1;
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mqtf_pkg.sv
hdl/mqtf_front.sv
hdl/mqtf_cmd_fifo.sv
hdl/mqtf_back.sv
hdl/multi_queue_ticket_fifo_top.sv
bench/multi_queue_ticket_fifo_top_tb.sv
